// ----- rtl/core/i2crm_pkg.sv -----
`default_nettype none

package i2crm_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_SHORT = 1'b0;
   localparam logic CSR_LONG  = 1'b1;

   localparam logic [7:0] SHORT_RESET = 8'd1;
   localparam logic [7:0] LONG_RESET  = 8'd50;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } i2crm_req_type;

   typedef struct packed {
      logic        scl;
      logic        sda_out;
      logic        sda_drive;
      logic        busy_res;
      logic        done_res;
      logic        nack_seen;
      logic [15:0] read_word;
   } i2crm_rsp_type;

   typedef struct packed {
      logic [7:0] short_delay_ticks;
      logic [7:0] long_delay_ticks;
   } i2crm_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/i2crm_seq.sv -----
`default_nettype none

module i2crm_seq
   import i2crm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire i2crm_req_type item,
   input  wire i2crm_cfg_type cfg,
   output i2crm_rsp_type      result
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
      PH_B0, PH_B1, PH_B2, PH_B3, PH_BX,
      PH_A0, PH_A1, PH_A2, PH_A3,
      PH_R0, PH_R1, PH_R2, PH_R3,
      PH_M0, PH_M1,
      PH_P0, PH_P1, PH_P2, PH_P3
   } phase_type;

   typedef enum logic [1:0] {KIND_START, KIND_SEND, KIND_RECV, KIND_STOP} kind_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  delay_ff, delay_in;
   logic [3:0]  bit_ff, bit_in;
   logic [2:0]  step_ff, step_in;
   logic [7:0]  shift_ff, shift_in;
   logic [6:0]  dev_ff, dev_in;
   logic [7:0]  reg_ff, reg_in;
   logic [7:0]  data_ff, data_in;
   logic        read_ff, read_in;
   logic [15:0] word_ff, word_in;
   logic        nack_ff, nack_in;

   // state after a possible start on this tick
   phase_type   ph1;
   logic [7:0]  dc1;
   logic [3:0]  bc1;
   logic [2:0]  bs1;
   logic        start;
   logic [2:0]  cur_idx, prev_idx;
   logic        cur_bit, prev_bit;
   logic        scl, sdo, drv, busy, done;
   logic [7:0]  len;
   logic        phase_end;
   logic [2:0]  nbs;
   kind_type    nkind;
   logic [7:0]  send_val;

   always_comb begin
      start = (phase_ff == PH_IDLE) && (item.opcode == OP_WRITE || item.opcode == OP_READ);
      ph1     = phase_ff;
      dc1     = delay_ff;
      bc1     = bit_ff;
      bs1     = step_ff;
      dev_in  = dev_ff;
      reg_in  = reg_ff;
      data_in = data_ff;
      read_in = read_ff;
      nack_in = nack_ff;
      if (start) begin
         dev_in  = item.device_address;
         reg_in  = item.register_address;
         data_in = item.write_data;
         read_in = (item.opcode == OP_READ);
         nack_in = 1'b0;
         bs1     = 3'd0;
         dc1     = 8'd0;
         bc1     = 4'd0;
         ph1     = PH_ST0;
      end

      cur_idx  = 3'd7 - bc1[2:0];
      prev_idx = 3'd7 - (bc1[2:0] - 3'd1);
      cur_bit  = shift_ff[cur_idx];
      prev_bit = (bc1 != 4'd0) ? shift_ff[prev_idx] : 1'b0;

      drv = 1'b1;
      unique case (ph1)
         PH_ST0: begin scl = (bs1 == 3'd0); sdo = 1'b1; end
         PH_ST1: begin scl = 1'b1; sdo = 1'b1; end
         PH_ST2: begin scl = 1'b1; sdo = 1'b0; end
         PH_ST3: begin scl = 1'b0; sdo = 1'b0; end
         PH_B0:  begin scl = 1'b0; sdo = prev_bit; end
         PH_B1:  begin scl = 1'b0; sdo = cur_bit; end
         PH_B2, PH_B3: begin scl = 1'b1; sdo = cur_bit; end
         PH_BX:  begin scl = 1'b1; sdo = shift_ff[0]; end
         PH_A0:  begin scl = 1'b0; sdo = shift_ff[0]; end
         PH_A1, PH_A2, PH_R1, PH_R2: begin scl = 1'b1; sdo = 1'b0; drv = 1'b0; end
         PH_A3, PH_R0, PH_R3: begin scl = 1'b0; sdo = 1'b0; drv = 1'b0; end
         PH_M0, PH_P0, PH_P1: begin scl = 1'b0; sdo = 1'b0; end
         PH_M1, PH_P2: begin scl = 1'b1; sdo = 1'b0; end
         PH_P3:  begin scl = 1'b1; sdo = 1'b1; end
         default: begin scl = 1'b1; sdo = 1'b1; end
      endcase
      busy = (ph1 != PH_IDLE);

      unique case (ph1)
         PH_ST1, PH_ST3, PH_P0, PH_P1, PH_P2: len = cfg.long_delay_ticks;
         default: len = cfg.short_delay_ticks;
      endcase
      phase_end = ({1'b0, dc1} + 9'd1) >= {1'b0, len};

      nbs = bs1 + 3'd1;
      if (read_in) begin
         unique case (nbs) inside
            3'd0, 3'd3: nkind = KIND_START;
            3'd5, 3'd6: nkind = KIND_RECV;
            3'd7:       nkind = KIND_STOP;
            default:    nkind = KIND_SEND;
         endcase
      end else begin
         unique case (nbs) inside
            3'd0:    nkind = KIND_START;
            3'd4:    nkind = KIND_STOP;
            default: nkind = KIND_SEND;
         endcase
      end
      if (nbs == 3'd1) begin
         send_val = {dev_in, 1'b0};
      end else if (nbs == 3'd2) begin
         send_val = reg_in;
      end else if (read_in) begin
         send_val = {dev_in, 1'b1};
      end else begin
         send_val = data_in;
      end

      phase_in = ph1;
      delay_in = dc1;
      bit_in   = bc1;
      step_in  = bs1;
      shift_in = shift_ff;
      word_in  = word_ff;
      done     = 1'b0;
      if (busy) begin
         if (phase_end) begin
            delay_in = 8'd0;
            unique case (ph1)
               PH_ST0: phase_in = PH_ST1;
               PH_ST1: phase_in = PH_ST2;
               PH_ST2: phase_in = PH_ST3;
               PH_B0:  phase_in = PH_B1;
               PH_B1:  phase_in = PH_B2;
               PH_B2:  phase_in = PH_B3;
               PH_B3: begin
                  if (bc1 >= 4'd7) begin
                     bit_in   = 4'd7;
                     phase_in = PH_BX;
                  end else begin
                     bit_in   = bc1 + 4'd1;
                     phase_in = PH_B0;
                  end
               end
               PH_BX: phase_in = PH_A0;
               PH_A0: phase_in = PH_A1;
               PH_A1: begin
                  if (item.sda_in) begin
                     nack_in = 1'b1;
                  end
                  phase_in = PH_A2;
               end
               PH_A2: phase_in = PH_A3;
               PH_R0: phase_in = PH_R1;
               PH_R1: begin
                  shift_in = {shift_ff[6:0], item.sda_in};
                  phase_in = PH_R2;
               end
               PH_R2: begin
                  bit_in   = bc1 + 4'd1;
                  phase_in = (bc1 >= 4'd7) ? PH_R3 : PH_R0;
               end
               PH_R3: begin
                  if (bs1 == 3'd5) begin
                     word_in[7:0] = shift_ff;
                  end else begin
                     word_in[15:8] = shift_ff;
                  end
                  phase_in = PH_M0;
               end
               PH_M0: phase_in = PH_M1;
               PH_P0: phase_in = PH_P1;
               PH_P1: phase_in = PH_P2;
               PH_P2: phase_in = PH_P3;
               PH_P3: begin
                  phase_in = PH_IDLE;
                  step_in  = 3'd0;
                  bit_in   = 4'd0;
                  done     = 1'b1;
               end
               PH_ST3, PH_A3, PH_M1: begin
                  step_in = nbs;
                  bit_in  = 4'd0;
                  unique case (nkind)
                     KIND_START: phase_in = PH_ST0;
                     KIND_SEND: begin
                        shift_in = send_val;
                        phase_in = PH_B0;
                     end
                     KIND_RECV: begin
                        shift_in = 8'd0;
                        phase_in = PH_R0;
                     end
                     default: phase_in = PH_P0;
                  endcase
               end
               default: phase_in = PH_IDLE;
            endcase
         end else begin
            delay_in = dc1 + 8'd1;
         end
      end

      result.scl       = scl;
      result.sda_out   = sdo;
      result.sda_drive = drv;
      result.busy_res  = busy;
      result.done_res  = done;
      result.nack_seen = nack_in;
      result.read_word = word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= 8'd0;
         bit_ff   <= 4'd0;
         step_ff  <= 3'd0;
         shift_ff <= 8'd0;
         dev_ff   <= 7'd0;
         reg_ff   <= 8'd0;
         data_ff  <= 8'd0;
         read_ff  <= 1'b0;
         word_ff  <= 16'd0;
         nack_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_ff   <= bit_in;
         step_ff  <= step_in;
         shift_ff <= shift_in;
         dev_ff   <= dev_in;
         reg_ff   <= reg_in;
         data_ff  <= data_in;
         read_ff  <= read_in;
         word_ff  <= word_in;
         nack_ff  <= nack_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/i2c_register_master.sv -----
// The result beat for a tick is registered and presented in the cycle after the tick is accepted.
// Throughput: one tick per cycle while rsp_ready is high; a result held with rsp_ready low
// stalls the input, and the sequencer state steps once per accepted beat.
// Reset: synchronous; bus phase idle, counters and read word cleared, short delay 1,
// long delay 50, output register empty.
`default_nettype none

module i2c_register_master
   import i2crm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire i2crm_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output i2crm_rsp_type      rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_index,
   input  wire logic [7:0]    csr_data
);

   i2crm_cfg_type cfg_ff;
   i2crm_rsp_type step_rsp;
   i2crm_rsp_type rsp_data_ff;
   logic          rsp_valid_ff;
   logic          accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   i2crm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (req_data),
      .cfg     (cfg_ff),
      .result  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_delay_ticks <= SHORT_RESET;
         cfg_ff.long_delay_ticks  <= LONG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHORT: cfg_ff.short_delay_ticks <= csr_data;
            CSR_LONG:  cfg_ff.long_delay_ticks  <= csr_data;
            default:   cfg_ff.long_delay_ticks  <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_rsp;
      end
   end

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat did not reach the output register");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled with room in the output register");

   a_released_low : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.sda_drive) |-> !rsp_data_ff.sda_out)
      else $error("sda_out high while SDA released");

   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res) |-> rsp_data_ff.busy_res)
      else $error("done without busy");

endmodule

`default_nettype wire
